// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file mtpc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked through reset as well
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- rtl/mtpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtpc_pkg
// Register map, pattern mode codes and fixed constants of the memory test
// pattern checker.
// ----------------------------------------------------------------------------
package mtpc_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TEST_MODE    = 3'd0;
  localparam logic [2:0] REG_FIXED_WORD   = 3'd1;
  localparam logic [2:0] REG_REGION_ITEMS = 3'd2;
  localparam logic [2:0] REG_BASE_ADDRESS = 3'd3;
  localparam logic [2:0] REG_MARCH_BIT    = 3'd4;
  localparam logic [2:0] REG_FILL_START   = 3'd5;

  // Pattern modes; unlisted codes fall back to the fixed word
  localparam logic [3:0] MODE_FIXED      = 4'd0;
  localparam logic [3:0] MODE_DECR       = 4'd1;
  localparam logic [3:0] MODE_NOT_DECR   = 4'd2;
  localparam logic [3:0] MODE_ADDR_XOR   = 4'd3;
  localparam logic [3:0] MODE_MARCH_ONE  = 4'd4;
  localparam logic [3:0] MODE_MARCH_ZERO = 4'd5;
  localparam logic [3:0] MODE_LCG        = 4'd6;
  localparam logic [3:0] MODE_BYTE_DECR  = 4'd7;
  localparam logic [3:0] MODE_INCR_LONG  = 4'd8;

  // Reset values and generator constants
  localparam logic [15:0] FIXED_RESET  = 16'hF0F0;
  localparam logic [19:0] REGION_RESET = 20'd262144;
  localparam logic [15:0] RAND_SEED    = 16'd433;
  localparam logic [15:0] RAND_ADD     = 16'd17623;
  localparam logic [19:0] COUNT_MAX    = 20'hFFFFF;

  localparam logic [31:0] MASK_WORD = 32'h0000_FFFF;
  localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
  localparam logic [31:0] MASK_LONG = 32'hFFFF_FFFF;

endpackage

// ----- rtl/memory_test_pattern_checker.sv -----
// Flow: a transaction accepted into the input register moves on to the result
// register when that is free or being read, and completes from there.
// Throughput: one item per cycle unless a result stalls; pattern generation
// and compare sit between the input and result registers in a single pass.
// Reset: synchronous, active high; clears the valid flags and the pass state
// (position 0, generator seed 433, error count and xor 0) and loads register
// defaults.
// ----------------------------------------------------------------------------
// memory_test_pattern_checker
// Read-back checker: works out the expected pattern word per position,
// compares it with the read data and keeps per-pass error totals.
// ----------------------------------------------------------------------------
module memory_test_pattern_checker #(
  parameter int MAX_ITEMS = 524288
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // read-back words
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [31:0] read_data,
  input  logic        first_of_pass,
  // check results
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] expected_value,
  output logic        mismatch,
  output logic [15:0] folded_xor,
  output logic [18:0] item_offset,
  output logic [19:0] error_count,
  output logic [15:0] accumulated_xor,
  output logic        beyond_region
);
  import mtpc_pkg::*;

  localparam int POS_W = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W = (POS_W > 20) ? POS_W : 20;

  // configuration registers
  logic [3:0]  test_mode;
  logic [15:0] fixed_word;
  logic [19:0] region_items;
  logic [31:0] base_address;
  logic [3:0]  march_bit;
  logic [31:0] fill_start;

  // pass state
  logic [POS_W-1:0] position;
  logic [15:0]      random_state;
  logic [19:0]      mismatch_total;
  logic [15:0]      xor_summary;

  // input register
  logic        s1_valid;
  logic [31:0] s1_data;
  logic        s1_first;

  logic advance;
  logic wr_en;

  // working values
  logic [POS_W-1:0] pos_cur;
  logic [15:0]      rand_cur;
  logic [19:0]      total_cur;
  logic [15:0]      xsum_cur;
  logic [CMP_W-1:0] region_ext;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] remaining;
  logic             beyond;
  logic [31:0]      addr;
  logic [15:0]      rand_step;
  logic [15:0]      march_one;
  logic [31:0]      exp_val;
  logic [31:0]      mask;
  logic [31:0]      diff;
  logic [15:0]      fold;
  logic             differs;

  logic [POS_W-1:0] position_next;
  logic [15:0]      random_state_next;
  logic [19:0]      mismatch_total_next;
  logic [15:0]      xor_summary_next;

  // handshakes
  assign pready     = 1'b1;
  assign wr_en      = psel & penable & pwrite;
  assign advance    = s1_valid & (~result_valid | result_ready);
  assign item_ready = ~s1_valid | advance;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      test_mode    <= MODE_FIXED;
      fixed_word   <= FIXED_RESET;
      region_items <= REGION_RESET;
      base_address <= '0;
      march_bit    <= '0;
      fill_start   <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_TEST_MODE:    test_mode    <= pwdata[3:0];
        REG_FIXED_WORD:   fixed_word   <= pwdata[15:0];
        REG_REGION_ITEMS: region_items <= pwdata[19:0];
        REG_BASE_ADDRESS: base_address <= pwdata;
        REG_MARCH_BIT:    march_bit    <= pwdata[3:0];
        REG_FILL_START:   fill_start   <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_TEST_MODE:    prdata = {28'd0, test_mode};
      REG_FIXED_WORD:   prdata = {16'd0, fixed_word};
      REG_REGION_ITEMS: prdata = {12'd0, region_items};
      REG_BASE_ADDRESS: prdata = base_address;
      REG_MARCH_BIT:    prdata = {28'd0, march_bit};
      REG_FILL_START:   prdata = fill_start;
      default:          prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_data  <= read_data;
      s1_first <= first_of_pass;
    end
  end

  // restart the pass state on the first transaction of a pass
  always_comb begin
    pos_cur   = s1_first ? '0 : position;
    rand_cur  = s1_first ? RAND_SEED : random_state;
    total_cur = s1_first ? '0 : mismatch_total;
    xsum_cur  = s1_first ? '0 : xor_summary;
  end

  // clamp the region size and check the position against it
  always_comb begin
    region_ext = CMP_W'(region_items);
    limit      = (region_ext > CMP_W'(MAX_ITEMS)) ? CMP_W'(MAX_ITEMS) : region_ext;
    beyond     = CMP_W'(pos_cur) >= limit;
    remaining  = limit - CMP_W'(pos_cur);
  end

  // pattern generation
  always_comb begin
    addr      = base_address + (32'(pos_cur) << 2);
    rand_step = rand_cur + (rand_cur << 2) + RAND_ADD;
    march_one = 16'h0001 << march_bit;
    mask      = MASK_WORD;
    case (test_mode)
      MODE_DECR:       exp_val = {16'd0, remaining[15:0]};
      MODE_NOT_DECR:   exp_val = {16'd0, ~remaining[15:0]};
      MODE_ADDR_XOR: begin
        exp_val = addr ^ (addr << 14);
        mask    = MASK_LONG;
      end
      MODE_MARCH_ONE:  exp_val = {16'd0, march_one};
      MODE_MARCH_ZERO: exp_val = {16'd0, ~march_one};
      MODE_LCG:        exp_val = {16'd0, rand_step};
      MODE_BYTE_DECR: begin
        exp_val = {24'd0, remaining[7:0]};
        mask    = MASK_BYTE;
      end
      MODE_INCR_LONG: begin
        exp_val = fill_start + 32'(pos_cur);
        mask    = MASK_LONG;
      end
      default:         exp_val = {16'd0, fixed_word};
    endcase
  end

  // compare and fold
  always_comb begin
    diff    = (exp_val ^ s1_data) & mask;
    fold    = diff[31:16] | diff[15:0];
    differs = |diff;
  end

  // next pass state; hold everything past the end of the region
  always_comb begin
    position_next       = pos_cur;
    random_state_next   = rand_cur;
    mismatch_total_next = total_cur;
    xor_summary_next    = xsum_cur;
    if (!beyond) begin
      position_next = pos_cur + 1'b1;
      if (test_mode == MODE_LCG) begin
        random_state_next = rand_step;
      end
      if (differs && total_cur != COUNT_MAX) begin
        mismatch_total_next = total_cur + 1'b1;
      end
      xor_summary_next = xsum_cur | fold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      random_state   <= RAND_SEED;
      mismatch_total <= '0;
      xor_summary    <= '0;
    end else if (advance) begin
      position       <= position_next;
      random_state   <= random_state_next;
      mismatch_total <= mismatch_total_next;
      xor_summary    <= xor_summary_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      expected_value  <= beyond ? '0 : exp_val;
      mismatch        <= ~beyond & differs;
      folded_xor      <= beyond ? '0 : fold;
      item_offset     <= beyond ? '0 : 19'(pos_cur);
      error_count     <= mismatch_total_next;
      accumulated_xor <= xor_summary_next;
      beyond_region   <= beyond;
    end
  end

endmodule

// ----- rtl/mtpc_checker.sv -----
// ----------------------------------------------------------------------------
// mtpc_checker
// Port-level checks on the result stream of the memory test pattern checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] expected_value,
  input logic        mismatch,
  input logic [15:0] folded_xor,
  input logic [15:0] accumulated_xor,
  input logic        beyond_region
);

  // no result straight after reset
  `ASSERT_NEXT(a_reset_empty, clk, rst, !result_valid)

  // past the region nothing is compared
  `ASSERT_IMPLY(a_beyond_quiet, clk, rst, result_valid && beyond_region, !mismatch && folded_xor == 16'd0 && expected_value == 32'd0)

  // a mismatch always leaves difference bits
  `ASSERT_IMPLY(a_mismatch_fold, clk, rst, result_valid, mismatch == (folded_xor != 16'd0))

  // the pass summary covers every difference reported
  `ASSERT_IMPLY(a_summary_cover, clk, rst, result_valid, (folded_xor & ~accumulated_xor) == 16'd0)

  // a stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk, !rst && result_valid && !result_ready, rst || (result_valid && $stable(expected_value) && $stable(folded_xor)))

endmodule

bind memory_test_pattern_checker mtpc_checker u_mtpc_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result_valid),
  .result_ready    (result_ready),
  .expected_value  (expected_value),
  .mismatch        (mismatch),
  .folded_xor      (folded_xor),
  .accumulated_xor (accumulated_xor),
  .beyond_region   (beyond_region)
);
